[rtl/assert_macros.svh]
// Assertion macros shared by the coalescer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication checked every clock, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`endif

[rtl/drc_pkg.sv]
// Package for the dirty region coalescer: beat types, codes, defaults.
package drc_pkg;
    localparam int BlockSlotsDef     = 16;
    localparam int RangesPerBlockDef = 8;

    localparam logic [1:0] KIND_MARK  = 2'd0;
    localparam logic [1:0] KIND_TAKE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] block_number;
        logic [15:0] start_offset;
        logic [15:0] byte_count;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] range_start;
        logic [16:0] range_length;
        logic        range_valid;
        logic        last_of_run;
        logic        has_ranges;
        logic        overflow;
    } t_out_beat;

    // Controller -> datapath commands.
    typedef struct packed {
        logic lookup;     // register the beat and search slots
        logic read_rng;   // read range at rd index of found slot, advance index
        logic scan_step;  // evaluate merge on read data
        logic commit;     // apply mark result / take clear
        logic emit;       // load output register
        logic emit_range; // output carries the read range
        logic emit_last;
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic [1:0] kind;
        logic       zero_cnt;
        logic       found;
        logic       has;
        logic       scan_done;  // index reached the range count
        logic       hit;        // merge found
        logic       out_busy;
    } t_sts;
endpackage

[rtl/dirty_region_coalescer_unit.sv]
// Top level of the dirty region coalescer: controller plus datapath.
// Query, take-miss and zero-length mark pass through the decode and done states, then the result is registered.
// Mark: decode, then one memory read and one compare per stored range of the block that is compared, then done.
// Take of n ranges: n results, each a range read and then an emit, bound by the range memory read port.
// Next beat can be accepted in the cycle after the last result is loaded; output register holds it.
// Reset (synchronous, active low) clears slot valid bits and counts; no clearing pass.
module dirty_region_coalescer_unit #(
    parameter int BLOCK_SLOTS      = drc_pkg::BlockSlotsDef,
    parameter int RANGES_PER_BLOCK = drc_pkg::RangesPerBlockDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  drc_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output drc_pkg::t_out_beat o_data
);
    drc_pkg::t_cmd cmd;
    drc_pkg::t_sts sts;

    // Sequencer: one beat in flight at a time.
    drc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Slot table, range memory, merge compare and output register.
    drc_datapath #(
        .BLOCK_SLOTS      (BLOCK_SLOTS),
        .RANGES_PER_BLOCK (RANGES_PER_BLOCK)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule

[rtl/drc_datapath.sv]
// Datapath: slot table, range memory, merge compare and output register.
`include "assert_macros.svh"
module drc_datapath #(
    parameter int BLOCK_SLOTS      = drc_pkg::BlockSlotsDef,
    parameter int RANGES_PER_BLOCK = drc_pkg::RangesPerBlockDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  drc_pkg::t_in_beat i_in,
    input  drc_pkg::t_cmd     i_cmd,
    output drc_pkg::t_sts     o_sts,
    output logic              o_valid,
    input  logic              i_ready,
    output drc_pkg::t_out_beat o_data
);
    localparam int SW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
    localparam int RW = (RANGES_PER_BLOCK > 1) ? $clog2(RANGES_PER_BLOCK) : 1;
    localparam int CW = $clog2(RANGES_PER_BLOCK + 1);
    localparam int DEPTH = BLOCK_SLOTS * RANGES_PER_BLOCK;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BLOCK_SLOTS-1:0] r_used;
    logic [15:0]            r_blk [BLOCK_SLOTS];
    logic [CW-1:0]          r_cnt [BLOCK_SLOTS];
    logic [15:0]            mem_start [DEPTH];
    logic [16:0]            mem_len [DEPTH];

    drc_pkg::t_in_beat r_beat;
    logic [SW-1:0]     r_slot;
    logic              r_found;
    logic              r_free_ok;
    logic [CW-1:0]     r_idx;
    logic [RW-1:0]     r_hit_idx;
    logic              r_hit;
    logic [15:0]       r_ms;
    logic [16:0]       r_ml;
    logic [15:0]       r_rd_start;
    logic [16:0]       r_rd_len;
    logic              r_has;
    logic              r_ovf;
    logic              r_valid;
    drc_pkg::t_out_beat r_out;

    // Slot search: match and lowest free slot.
    logic [SW-1:0] s_match, s_free;
    logic          s_found, s_any_free;
    always_comb begin
        s_match = '0; s_found = 1'b0; s_free = '0; s_any_free = 1'b0;
        for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
            if (r_used[i] && r_blk[i] == i_in.block_number) begin
                s_match = SW'(i); s_found = 1'b1;
            end
            if (!r_used[i]) begin
                s_free = SW'(i); s_any_free = 1'b1;
            end
        end
    end

    logic [CW-1:0] cur_cnt;
    assign cur_cnt = r_found ? r_cnt[r_slot] : '0;

    // index of the range whose data is in the read register
    logic [CW-1:0] prev_idx;
    assign prev_idx = r_idx - CW'(1);

    // Merge test on the range just read.
    logic [16:0] off17, new_end, rs17, re17, ms, me;
    logic        fits;
    always_comb begin
        off17   = {1'b0, r_beat.start_offset};
        new_end = off17 + {1'b0, r_beat.byte_count};
        rs17    = {1'b0, r_rd_start};
        re17    = rs17 + r_rd_len;
        fits    = (off17 <= re17) && (new_end >= rs17);
        ms      = (rs17 < off17) ? rs17 : off17;
        me      = (re17 > new_end) ? re17 : new_end;
    end

    logic [AW-1:0] rd_addr, wr_addr;
    assign rd_addr = AW'(r_slot) * AW'(RANGES_PER_BLOCK) + AW'(r_idx[RW-1:0]);
    assign wr_addr = AW'(r_slot) * AW'(RANGES_PER_BLOCK)
                   + AW'(r_hit ? r_hit_idx : cur_cnt[RW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_rng) begin
            r_rd_start <= mem_start[rd_addr];
            r_rd_len   <= mem_len[rd_addr];
        end
        if (i_cmd.commit && r_beat.kind == drc_pkg::KIND_MARK && !r_ovf
            && r_beat.byte_count != 16'd0 && (r_hit || r_free_ok)) begin
            mem_start[wr_addr] <= r_hit ? r_ms : r_beat.start_offset;
            mem_len[wr_addr]   <= r_hit ? r_ml : {1'b0, r_beat.byte_count};
        end
    end

    logic add_ok;
    assign add_ok = (r_found || r_free_ok) && (32'(cur_cnt) < RANGES_PER_BLOCK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_beat    <= i_in;
            r_slot    <= s_found ? s_match : s_free;
            r_found   <= s_found;
            r_free_ok <= s_found || s_any_free;
            r_has     <= s_found && (r_cnt[s_match] != '0);
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
            r_ms      <= '0;
            r_ml      <= '0;
        end else if (i_cmd.scan_step) begin
            if (fits && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= prev_idx[RW-1:0];
                r_ms      <= ms[15:0];
                r_ml      <= me - ms;
            end
        end else if (i_cmd.read_rng) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_step && !fits && !r_hit
            && 32'(r_idx) >= 32'(cur_cnt) && !add_ok)
            r_ovf <= 1'b1;
        else if (i_cmd.lookup)
            r_ovf <= (i_in.kind == drc_pkg::KIND_MARK) && (i_in.byte_count != 16'd0)
                     && !s_found && !s_any_free;
        if (i_cmd.emit) begin
            r_out.range_start  <= i_cmd.emit_range ? r_rd_start : '0;
            r_out.range_length <= i_cmd.emit_range ? r_rd_len : '0;
            r_out.range_valid  <= i_cmd.emit_range;
            r_out.last_of_run  <= i_cmd.emit_last;
            r_out.has_ranges   <= r_has;
            r_out.overflow     <= r_ovf && r_beat.kind == drc_pkg::KIND_MARK;
        end
    end

    // Slot table and valid output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < BLOCK_SLOTS; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cmd.emit) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (i_cmd.commit) begin
                if (r_beat.kind == drc_pkg::KIND_TAKE && r_found) begin
                    r_used[r_slot] <= 1'b0;
                    r_cnt[r_slot]  <= '0;
                end else if (r_beat.kind == drc_pkg::KIND_MARK && !r_ovf
                             && r_beat.byte_count != 16'd0 && !r_hit && add_ok) begin
                    r_used[r_slot] <= 1'b1;
                    r_blk[r_slot]  <= r_beat.block_number;
                    r_cnt[r_slot]  <= cur_cnt + CW'(1);
                end
            end
        end
    end

    always_comb begin
        o_sts.kind      = r_beat.kind;
        o_sts.zero_cnt  = (r_beat.byte_count == 16'd0) || r_ovf;
        o_sts.found     = r_found;
        o_sts.has       = r_has;
        o_sts.scan_done = (r_idx >= cur_cnt);
        o_sts.hit       = r_hit;
        o_sts.out_busy  = r_valid && !i_ready;
    end
    assign o_valid = r_valid;
    assign o_data  = r_out;

    `ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, r_found, 32'(cur_cnt) <= RANGES_PER_BLOCK)
    `ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !(r_valid && !i_ready))
    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid)
endmodule

[rtl/drc_ctrl.sv]
// Controller state machine sequencing lookup, scan, commit and emission.
`include "assert_macros.svh"
module drc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  drc_pkg::t_sts i_sts,
    output drc_pkg::t_cmd o_cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_TRD  = 3'd4;
    localparam logic [2:0] ST_TEM  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_rd_pend, n_rd_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rd_pend = 1'b0;
        o_cmd     = '0;
        o_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.lookup = 1'b1;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                if (i_sts.kind == drc_pkg::KIND_MARK && !i_sts.zero_cnt) begin
                    n_state = ST_SCAN;
                end else if (i_sts.kind == drc_pkg::KIND_TAKE && i_sts.has) begin
                    n_state = ST_TRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                // read one range, then test it the next cycle
                if (r_rd_pend) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_sts.scan_done || i_sts.hit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.read_rng = 1'b1;
                    n_rd_pend = 1'b1;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit    = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TRD: begin
                o_cmd.read_rng = 1'b1;
                n_state = ST_TEM;
            end
            ST_TEM: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_range = 1'b1;
                    o_cmd.emit_last  = i_sts.scan_done;
                    if (i_sts.scan_done) begin
                        o_cmd.commit = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_TRD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_one_op, i_clk, i_rst_n, 1'b1, !(o_cmd.read_rng && o_cmd.scan_step))
    `ASSERT_NEXT(a_pend_step, i_clk, i_rst_n, r_state == ST_SCAN && o_cmd.read_rng,
                 o_cmd.scan_step)
endmodule

[test/testbench.sv]
// Self-checking testbench for the dirty region coalescer unit.
module testbench;
    localparam int NSLOT = drc_pkg::BlockSlotsDef;
    localparam int NRNG  = drc_pkg::RangesPerBlockDef;
    localparam int WATCHDOG_LIMIT = 4000;

    // Range tracker model plus queue of expected output beats.
    class range_scoreboard;
        bit          slot_busy [NSLOT];
        bit   [15:0] slot_blk  [NSLOT];
        int          slot_cnt  [NSLOT];
        bit   [15:0] rng_start [NSLOT][NRNG];
        bit   [16:0] rng_len   [NSLOT][NRNG];
        drc_pkg::t_out_beat pending_beats[$];
        int          errors;

        function void add_expected(drc_pkg::t_out_beat r);
            pending_beats.insert(pending_beats.size(), r);
        endfunction

        function int find_slot(bit [15:0] blk);
            for (int i = 0; i < NSLOT; i++)
                if (slot_busy[i] && slot_blk[i] == blk) return i;
            return -1;
        endfunction

        function bit apply_mark(bit [15:0] blk, bit [16:0] off, bit [16:0] cnt);
            int s;
            bit [16:0] e;
            bit [16:0] rs;
            bit [16:0] re;
            s = find_slot(blk);
            e = off + cnt;
            if (s < 0) begin
                for (int i = 0; i < NSLOT; i++)
                    if (!slot_busy[i]) begin
                        s = i;
                        break;
                    end
                if (s < 0) return 1'b1;
                slot_busy[s] = 1'b1;
                slot_blk[s] = blk;
                slot_cnt[s] = 0;
            end
            // merge into first overlapping or touching range, no cascade
            for (int i = 0; i < slot_cnt[s]; i++) begin
                rs = rng_start[s][i];
                re = rs + rng_len[s][i];
                if (off <= re && e >= rs) begin
                    if (off < rs) rs = off;
                    if (e > re) re = e;
                    rng_start[s][i] = rs[15:0];
                    rng_len[s][i] = re - rs;
                    return 1'b0;
                end
            end
            if (slot_cnt[s] >= NRNG) return 1'b1;
            rng_start[s][slot_cnt[s]] = off[15:0];
            rng_len[s][slot_cnt[s]] = cnt;
            slot_cnt[s]++;
            return 1'b0;
        endfunction

        function void note_input(drc_pkg::t_in_beat b);
            int s;
            bit has;
            drc_pkg::t_out_beat r;
            s = find_slot(b.block_number);
            has = (s >= 0) && (slot_cnt[s] > 0);
            r = '0;
            r.last_of_run = 1'b1;
            r.has_ranges = has;
            if (b.kind == drc_pkg::KIND_MARK) begin
                if (b.byte_count != 0)
                    r.overflow = apply_mark(b.block_number, b.start_offset, b.byte_count);
                add_expected(r);
            end else if (b.kind == drc_pkg::KIND_TAKE) begin
                if (!has) begin
                    if (s >= 0) slot_busy[s] = 1'b0;
                    add_expected(r);
                end else begin
                    for (int i = 0; i < slot_cnt[s]; i++) begin
                        r.range_start = rng_start[s][i];
                        r.range_length = rng_len[s][i];
                        r.range_valid = 1'b1;
                        r.last_of_run = (i == slot_cnt[s] - 1);
                        add_expected(r);
                    end
                    slot_busy[s] = 1'b0;
                    slot_cnt[s] = 0;
                end
            end else begin
                add_expected(r);
            end
        endfunction

        function void check_output(drc_pkg::t_out_beat got);
            drc_pkg::t_out_beat want;
            if (pending_beats.size() == 0) begin
                report_error($sformatf("unexpected beat %h", got));
                return;
            end
            want = pending_beats.pop_front();
            if (got.range_start !== want.range_start)
                report_error($sformatf("range_start %h exp %h", got.range_start,
                    want.range_start));
            if (got.range_length !== want.range_length)
                report_error($sformatf("range_length %h exp %h", got.range_length,
                    want.range_length));
            if (got.range_valid !== want.range_valid)
                report_error($sformatf("range_valid %b exp %b", got.range_valid,
                    want.range_valid));
            if (got.last_of_run !== want.last_of_run)
                report_error($sformatf("last_of_run %b exp %b", got.last_of_run,
                    want.last_of_run));
            if (got.has_ranges !== want.has_ranges)
                report_error($sformatf("has_ranges %b exp %b", got.has_ranges,
                    want.has_ranges));
            if (got.overflow !== want.overflow)
                report_error($sformatf("overflow %b exp %b", got.overflow, want.overflow));
        endfunction

        function void report_error(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    drc_pkg::t_in_beat  i_data;
    logic               o_valid;
    logic               i_ready;
    drc_pkg::t_out_beat o_data;

    range_scoreboard tracker;
    int  idle_cycles;
    bit  busy_phase;   // when clear, neither side idles

    dirty_region_coalescer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Score both handshakes at the edge; the watchdog counts quiet cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) tracker.note_input(i_data);
            if (o_valid && i_ready) tracker.check_output(o_data);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stalls at random, about 13 percent of cycles, while busy_phase is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !(busy_phase && $urandom_range(99) < 13);
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one beat and hold it until taken, with an optional gap first.
    // Valid stays high between back-to-back beats; it drops only in a gap.
    task automatic send_beat(drc_pkg::t_in_beat b);
        while (busy_phase && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_op(logic [1:0] k, logic [15:0] blk, logic [15:0] off,
                           logic [15:0] cnt);
        drc_pkg::t_in_beat b;
        b.kind = k;
        b.block_number = blk;
        b.start_offset = off;
        b.byte_count = cnt;
        send_beat(b);
    endtask

    // Mostly a small pool of blocks so merges, fills and takes happen often.
    function automatic logic [15:0] pick_block();
        if ($urandom_range(9) < 8) return 16'h0100 + 16'($urandom_range(19));
        return 16'($urandom);
    endfunction

    initial begin
        drc_pkg::t_in_beat b;
        tracker = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        idle_cycles = 0;
        busy_phase = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty take/query, zero length, merge, touch, extremes
        send_op(drc_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_op(drc_pkg::KIND_TAKE,  16'hFFFF, 16'h0000, 16'h0000);
        send_op(drc_pkg::KIND_MARK,  16'h0001, 16'h0010, 16'h0000);
        send_op(drc_pkg::KIND_MARK,  16'h0001, 16'h0010, 16'h0010);
        send_op(drc_pkg::KIND_MARK,  16'h0001, 16'h0020, 16'h0008);   // touches end
        send_op(drc_pkg::KIND_MARK,  16'h0001, 16'h0004, 16'h000C);   // touches start
        send_op(drc_pkg::KIND_MARK,  16'h0001, 16'h0100, 16'h0004);   // disjoint
        send_op(drc_pkg::KIND_MARK,  16'h0001, 16'hFFFF, 16'hFFFF);   // largest end
        send_op(drc_pkg::KIND_QUERY, 16'h0001, 16'h0000, 16'h0000);
        send_op(2'd3,                16'h0001, 16'hFFFF, 16'hFFFF);
        send_op(drc_pkg::KIND_TAKE,  16'h0001, 16'h0000, 16'h0000);
        send_op(drc_pkg::KIND_TAKE,  16'h0001, 16'h0000, 16'h0000);
        for (int i = 0; i < NRNG + 1; i++)                   // fill list, then overflow
            send_op(drc_pkg::KIND_MARK, 16'h0002, 16'(i * 16), 16'h0004);
        for (int i = 0; i < NSLOT; i++)                      // fill slot table
            send_op(drc_pkg::KIND_MARK, 16'h8000 + 16'(i), 16'h0000, 16'h0001);
        send_op(drc_pkg::KIND_MARK, 16'hABCD, 16'h0000, 16'h0001);    // no free slot
        send_op(drc_pkg::KIND_TAKE, 16'h0002, 16'h0000, 16'h0000);
        for (int i = 0; i < NSLOT; i++)
            send_op(drc_pkg::KIND_TAKE, 16'h8000 + 16'(i), 16'h0000, 16'h0000);

        // random: mostly marks in a few blocks with small ranges
        for (int n = 0; n < 165; n++) begin
            busy_phase = !(n >= 60 && n < 110);
            b.kind = ($urandom_range(9) < 6) ? drc_pkg::KIND_MARK :
                     ($urandom_range(3) == 0) ? 2'($urandom_range(2, 3)) :
                     drc_pkg::KIND_TAKE;
            b.block_number = pick_block();
            if ($urandom_range(9) < 8) begin
                b.start_offset = 16'($urandom_range(600));
                b.byte_count = 16'($urandom_range(40));
            end else begin
                b.start_offset = 16'($urandom);
                b.byte_count = 16'($urandom);
            end
            send_beat(b);
        end
        i_valid <= 1'b0;
        busy_phase = 1'b1;

        while (tracker.pending_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0 && !o_valid) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
